>>> src/pks_pkg.sv
package pks_pkg;

  localparam int unsigned KeyRegW  = 80;
  localparam int unsigned MasterW  = 24;
  localparam int unsigned SubkeyW  = 24;
  localparam int unsigned RoundW   = 4;
  localparam int unsigned RconW    = 5;
  localparam int unsigned SubkeyLo = 16;
  localparam int unsigned RconLo   = 15;
  localparam int unsigned RotRight = 19;

  localparam logic [RoundW-1:0] LAST_ROUND = 4'd10;

  typedef logic [KeyRegW-1:0] key_reg_t;
  typedef logic [RoundW-1:0]  round_t;

  // Four-bit substitution box applied to the top nibble of the key register.
  function automatic logic [3:0] sbox4(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0:    y = 4'hC;
      4'h1:    y = 4'h5;
      4'h2:    y = 4'h6;
      4'h3:    y = 4'hB;
      4'h4:    y = 4'h9;
      4'h5:    y = 4'h0;
      4'h6:    y = 4'hA;
      4'h7:    y = 4'hD;
      4'h8:    y = 4'h3;
      4'h9:    y = 4'hE;
      4'hA:    y = 4'hF;
      4'hB:    y = 4'h8;
      4'hC:    y = 4'h4;
      4'hD:    y = 4'h7;
      4'hE:    y = 4'h1;
      4'hF:    y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

endpackage

>>> src/present24_key_schedule_unit.sv
// Key schedule for a PRESENT-style cipher with a 24-bit master key.
// Input channel: in_valid/in_ready with in_master_key. Each accepted key
// is placed in bits 79..56 of an 80-bit key register, lower bits zero.
// Result channel: out_valid/out_ready with out_subkey, out_round_index and
// out_last. Every key yields eleven results, subkeys 0 through 10 in order,
// and out_last marks subkey 10. Subkey 0 is always zero.
// Flow: an accepted key is loaded into the key register, and each subkey
// then passes into the output register; one round is computed per cycle
// between the two while the output register can take it. A new key is
// taken in the same cycle that subkey 10 enters the output register, so
// keys can follow one another with no gap on the result channel.
// When the receiver stalls, the output register holds its result and the
// round sequencer waits; in_ready stays low until the last round is loaded.
// Reset (rst_n low at a clock edge) drops any run in progress and empties
// the output register; the block is ready for a key in the next cycle.
module present24_key_schedule_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] in_master_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_subkey,
  output logic [3:0]  out_round_index,
  output logic        out_last
);

  logic              busy_r, busy_nxt;
  pks_pkg::key_reg_t key_r, key_nxt;
  pks_pkg::round_t   rnd_r, rnd_nxt;
  pks_pkg::key_reg_t key_round;
  pks_pkg::round_t   rnd_inc;

  logic                        out_valid_r, out_valid_nxt;
  logic [pks_pkg::SubkeyW-1:0] out_subkey_r, out_subkey_nxt;
  pks_pkg::round_t             out_round_r, out_round_nxt;
  logic                        out_last_r, out_last_nxt;

  logic out_load;
  logic in_take;
  logic at_last;

  assign rnd_inc = rnd_r + 4'd1;
  assign at_last = (rnd_r == pks_pkg::LAST_ROUND);

  pks_round u_round (
    .key_i   (key_r),
    .round_i (rnd_inc),
    .key_o   (key_round)
  );

  assign out_load = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || (out_load && at_last);
  assign in_take  = in_valid && in_ready;

  always_comb begin
    busy_nxt = busy_r;
    key_nxt  = key_r;
    rnd_nxt  = rnd_r;
    if (in_take) begin
      busy_nxt = 1'b1;
      key_nxt  = {in_master_key, {(pks_pkg::KeyRegW - pks_pkg::MasterW){1'b0}}};
      rnd_nxt  = '0;
    end else if (out_load) begin
      key_nxt = key_round;
      rnd_nxt = rnd_inc;
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_subkey_nxt = out_subkey_r;
    out_round_nxt  = out_round_r;
    out_last_nxt   = out_last_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_subkey_nxt = key_r[pks_pkg::SubkeyLo +: pks_pkg::SubkeyW];
      out_round_nxt  = rnd_r;
      out_last_nxt   = at_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    rnd_r        <= rnd_nxt;
    out_subkey_r <= out_subkey_nxt;
    out_round_r  <= out_round_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_subkey      = out_subkey_r;
  assign out_round_index = out_round_r;
  assign out_last        = out_last_r;

endmodule

>>> src/pks_round.sv
module pks_round (
  input  pks_pkg::key_reg_t key_i,
  input  pks_pkg::round_t   round_i,
  output pks_pkg::key_reg_t key_o
);

  pks_pkg::key_reg_t rot;
  pks_pkg::key_reg_t subst;
  logic [pks_pkg::RconW-1:0] rcon;

  // A left rotation by 61 is the same as a right rotation by 19.
  assign rot   = {key_i[pks_pkg::RotRight-1:0], key_i[pks_pkg::KeyRegW-1:pks_pkg::RotRight]};
  assign subst = {pks_pkg::sbox4(rot[pks_pkg::KeyRegW-1 -: 4]), rot[pks_pkg::KeyRegW-5:0]};
  assign rcon  = {1'b0, round_i};

  always_comb begin
    key_o = subst;
    key_o[pks_pkg::RconLo +: pks_pkg::RconW] = subst[pks_pkg::RconLo +: pks_pkg::RconW] ^ rcon;
  end

endmodule

>>> src/pks_checker.sv
module pks_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_subkey,
  input logic [3:0]  out_round_index,
  input logic        out_last
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_subkey)
      && $stable(out_round_index) && $stable(out_last))
    else $error("result changed while stalled");

  // The flag marks exactly the final subkey.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_round_index == pks_pkg::LAST_ROUND)))
    else $error("last flag does not match round index");

  // The first subkey of every run is zero.
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_round_index == 4'd0) |-> (out_subkey == 24'd0))
    else $error("subkey zero is not zero");

  // Within a run the next subkey follows right after the current one is taken.
  a_next_round: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_round_index == $past(out_round_index) + 4'd1))
    else $error("round sequence broken");

  // Once a key is taken, in_ready goes low, so a second key cannot follow it at once.
  a_no_double_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second key taken during a run");

endmodule

bind present24_key_schedule_unit pks_checker u_pks_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_subkey      (out_subkey),
  .out_round_index (out_round_index),
  .out_last        (out_last)
);

>>> tb/present24_key_schedule_checker.sv
`timescale 1ns / 100ps

module present24_key_schedule_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [pks_pkg::MasterW-1:0] in_master_key,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [pks_pkg::SubkeyW-1:0] out_subkey,
  input  pks_pkg::round_t             out_round_index,
  input  logic                        out_last,
  output int unsigned                 mismatch_count,
  output int unsigned                 subkeys_pending
);

  // S-box entries packed four bits each, entry 0 in the low nibble.
  localparam logic [63:0] SBOX_NIBBLES = 64'h2174_8FE3_DA09_B65C;
  localparam int unsigned NumSubkeys = 11;

  typedef struct packed {
    logic [pks_pkg::SubkeyW-1:0] subkey;
    pks_pkg::round_t             round;
    logic                        last;
  } subkey_rec_t;

  subkey_rec_t subkeys_due[$];
  subkey_rec_t want;
  int unsigned miss_total = 0;
  int unsigned due_now = 0;

  assign mismatch_count  = miss_total;
  assign subkeys_pending = due_now;

  task automatic report_mismatch(input string what,
                                 input logic [pks_pkg::SubkeyW-1:0] got,
                                 input logic [pks_pkg::SubkeyW-1:0] wanted);
    $display("%0t: %s: got %h, expected %h", $time, what, got, wanted);
    miss_total++;
  endtask

  // Runs the whole schedule for one master key and queues its subkeys in order.
  function automatic void queue_subkeys(input logic [pks_pkg::MasterW-1:0] key);
    pks_pkg::key_reg_t kr;
    subkey_rec_t       rec;
    kr = '0;
    kr[pks_pkg::KeyRegW-1 -: pks_pkg::MasterW] = key;
    for (int r = 0; r < NumSubkeys; r++) begin
      if (r != 0) begin
        kr = {kr[pks_pkg::RotRight-1:0], kr[pks_pkg::KeyRegW-1:pks_pkg::RotRight]};
        kr[pks_pkg::KeyRegW-1 -: 4] = SBOX_NIBBLES[{kr[pks_pkg::KeyRegW-1 -: 4], 2'b00} +: 4];
        kr[pks_pkg::RconLo +: pks_pkg::RconW] =
          kr[pks_pkg::RconLo +: pks_pkg::RconW] ^ pks_pkg::RconW'(r);
      end
      rec.subkey = kr[pks_pkg::SubkeyLo +: pks_pkg::SubkeyW];
      rec.round  = pks_pkg::round_t'(r);
      rec.last   = (rec.round == pks_pkg::LAST_ROUND);
      subkeys_due.push_back(rec);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      subkeys_due.delete();
      due_now <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (subkeys_due.size() == 0) begin
          report_mismatch("subkey with no request pending", out_subkey, '0);
        end else begin
          want = subkeys_due.pop_front();
          if (out_subkey !== want.subkey) begin
            report_mismatch("subkey", out_subkey, want.subkey);
          end
          if (out_round_index !== want.round) begin
            report_mismatch("round_index", pks_pkg::SubkeyW'(out_round_index),
                            pks_pkg::SubkeyW'(want.round));
          end
          if (out_last !== want.last) begin
            report_mismatch("last", pks_pkg::SubkeyW'(out_last),
                            pks_pkg::SubkeyW'(want.last));
          end
        end
      end
      if (in_valid && in_ready) begin
        queue_subkeys(in_master_key);
      end
      due_now <= subkeys_due.size();
    end
  end

endmodule

>>> tb/tb_present24_key_schedule_unit.sv
`timescale 1ns / 100ps

module tb_present24_key_schedule_unit;

  localparam int unsigned NumKeys       = 460;
  localparam int unsigned CalmTail      = 60;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 20;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [pks_pkg::MasterW-1:0] in_master_key = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [pks_pkg::SubkeyW-1:0] out_subkey;
  pks_pkg::round_t             out_round_index;
  logic                        out_last;

  logic        idle_on = 1'b1;
  int unsigned ready_hold = 0;
  int unsigned quiet_cycles = 0;
  int unsigned keys_sent = 0;
  int unsigned mismatch_count;
  int unsigned subkeys_pending;

  always #6 clk = ~clk;

  present24_key_schedule_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_master_key  (in_master_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_subkey     (out_subkey),
    .out_round_index(out_round_index),
    .out_last       (out_last)
  );

  present24_key_schedule_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_master_key  (in_master_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_subkey     (out_subkey),
    .out_round_index(out_round_index),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .subkeys_pending(subkeys_pending)
  );

  // Receiver stalls in bursts while idling is enabled.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (ready_hold != 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_present24_key_schedule_unit: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one key and returns at the edge where it is taken. Valid stays high
  // into the next request unless an idle burst is inserted first.
  task automatic send_key(input logic [pks_pkg::MasterW-1:0] key);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_master_key <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    keys_sent++;
    // Idling pauses every fourth stretch of 50 requests and stops near the end.
    idle_on <= ((keys_sent / 50) % 4 != 3) && (keys_sent < NumKeys - CalmTail);
  endtask

  function automatic logic [pks_pkg::MasterW-1:0] random_key();
    case ($urandom_range(0, 9))
      0:       return pks_pkg::MasterW'(1) << $urandom_range(0, pks_pkg::MasterW - 1);
      1:       return ~(pks_pkg::MasterW'(1) << $urandom_range(0, pks_pkg::MasterW - 1));
      2:       return pks_pkg::MasterW'($urandom) & pks_pkg::MasterW'($urandom)
                      & pks_pkg::MasterW'($urandom);
      default: return pks_pkg::MasterW'($urandom);
    endcase
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_key(24'h000000);
    send_key(24'hFFFFFF);
    send_key(24'hAAAAAA);
    send_key(24'h555555);
    send_key(24'h800000);
    send_key(24'h000001);
    for (int n = 0; n < 16; n++) begin
      send_key({4'(n), 20'($urandom)});
    end

    while (keys_sent < NumKeys) begin
      send_key(random_key());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (subkeys_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_present24_key_schedule_unit: clean");
    end else begin
      $display("tb_present24_key_schedule_unit: errors");
    end
    $finish;
  end

endmodule
